>>> hdl/rdt_pkg.sv
// Package for the reliable delivery tracker: word types, action and result codes, register map.
package rdt_pkg;

  localparam int SEQ_W  = 32;
  localparam int TIME_W = 32;
  localparam int TO_W   = 20;

  localparam logic [2:0] ACT_SEND  = 3'd0;
  localparam logic [2:0] ACT_RECV  = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_DRAIN = 3'd4;

  localparam logic [2:0] KIND_ASSIGNED = 3'd0;
  localparam logic [2:0] KIND_RECEIVE  = 3'd1;
  localparam logic [2:0] KIND_ACK      = 3'd2;
  localparam logic [2:0] KIND_FAIL     = 3'd3;
  localparam logic [2:0] KIND_PENDING  = 3'd4;
  localparam logic [2:0] KIND_NOTHING  = 3'd5;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [TO_W-1:0] TIMEOUT_RESET = 20'd5000;

  typedef struct packed {
    logic [2:0]        action;
    logic [SEQ_W-1:0]  seq_in;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SEQ_W-1:0] seq_out;
    logic             ok;
    logic             pending_nonempty;
    logic             last;
  } out_word_t;

endpackage

>>> hdl/rdt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/reliable_delivery_tracker.sv
// Top level of the reliable delivery tracker: command port, in-flight table walk, pending list.
//
// The block takes one command word when start is high and busy is low, and answers with one
// or more result words, each shown for a single cycle with strobe high; the receiver cannot
// stall, so every result must be taken in the cycle it appears. Send, ack and tick walk the
// whole in-flight table one slot per cycle through the read port of the table memory, and
// busy stays high from accept to result. Receive, drain of an empty list and undefined
// action codes answer in the cycle after accept and leave busy low, so the next command may
// enter at once. A drain of n pending acks keeps busy high and delivers n result words, one
// per cycle. The in-flight slots carry valid bits in flip-flops cleared by reset, so no
// clearing pass is needed after reset. The timeout register sits at byte address 0 of the
// APB port and must be written only while the block is idle; the block does not enforce it.
module reliable_delivery_tracker #(
  parameter int IN_FLIGHT_DEPTH = 32,
  parameter int PENDING_DEPTH   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rdt_pkg::in_word_t item,
  output logic              strobe,
  output rdt_pkg::out_word_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = $clog2(IN_FLIGHT_DEPTH);
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int SW = rdt_pkg::SEQ_W;
  localparam int TW = rdt_pkg::TIME_W;
  localparam int TOW = rdt_pkg::TO_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(IN_FLIGHT_DEPTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0] state;

  // Configuration register.
  logic [TOW-1:0] timeout_ms;
  logic           cfg_write;

  // Latched command.
  logic [2:0]    op;
  logic [SW-1:0] seq_q;
  logic [TW-1:0] now_q;

  // Tracker state outside the table memory.
  logic [SW-1:0]              next_seq;
  logic [IN_FLIGHT_DEPTH-1:0] flight_valid;
  logic [SW-1:0]              pending_first;
  logic [CW-1:0]              pending_count;

  // Table walk: issue side, and the data side that follows it in the next cycle.
  logic [IW-1:0] idx;
  logic          issuing;
  logic          rd_vld;
  logic          rd_last;
  logic [IW-1:0] rd_idx;

  // Best candidate found so far in the walk.
  logic          found;
  logic [IW-1:0] pick;
  logic [TW-1:0] best_age;
  logic [SW-1:0] best_seq;

  // Drain progress.
  logic [CW-1:0] drain_k;
  logic [CW-1:0] drain_n;

  // Table memory: sequence number in the upper half, send time in the lower half.
  logic                ram_we;
  logic [SW+TW-1:0]    ram_wdata;
  logic [SW+TW-1:0]    ram_rdata;
  logic [SW-1:0]       rd_seq;
  logic [TW-1:0]       rd_time;

  logic          accept;
  logic [TW-1:0] age;
  logic          slot_v;
  logic          hit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3:2] == rdt_pkg::REG_TIMEOUT) ? {{(32-TOW){1'b0}}, timeout_ms}
                                                         : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= rdt_pkg::TIMEOUT_RESET;
    end else if (cfg_write && paddr[3:2] == rdt_pkg::REG_TIMEOUT) begin
      timeout_ms <= pwdata[TOW-1:0];
    end
  end

  // The memory is written only in the finishing cycle of a send, and read only during a
  // walk; a walk never starts in the same cycle, so reads and writes of one slot never
  // overlap and no forwarding is needed.
  assign ram_we    = (state == S_FIN) && (op == rdt_pkg::ACT_SEND) && found;
  assign ram_wdata = {next_seq, now_q};
  assign rd_seq    = ram_rdata[SW+TW-1:TW];
  assign rd_time   = ram_rdata[TW-1:0];

  rdt_ram #(
    .WIDTH(SW + TW),
    .DEPTH(IN_FLIGHT_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pick),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Per-slot test on the word just returned by the memory. A send looks for the lowest free
  // slot, an ack for the lowest valid slot holding the number, and a tick for the oldest
  // expired slot, where a tie keeps the lower slot because only a strictly greater age wins.
  always_comb begin
    age    = now_q - rd_time;
    slot_v = flight_valid[rd_idx];
    case (op)
      rdt_pkg::ACT_SEND: hit = !slot_v && !found;
      rdt_pkg::ACT_ACK:  hit = slot_v && (rd_seq == seq_q) && !found;
      rdt_pkg::ACT_TICK: hit = slot_v && (age > {{(TW-TOW){1'b0}}, timeout_ms})
                               && (!found || age > best_age);
      default:           hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      strobe        <= 1'b0;
      next_seq      <= '0;
      flight_valid  <= '0;
      pending_first <= '0;
      pending_count <= '0;
      issuing       <= 1'b0;
      rd_vld        <= 1'b0;
      rd_last       <= 1'b0;
      found         <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= item.action;
            seq_q <= item.seq_in;
            now_q <= item.now_ms;
            case (item.action)
              rdt_pkg::ACT_SEND, rdt_pkg::ACT_ACK, rdt_pkg::ACT_TICK: begin
                state   <= S_SCAN;
                idx     <= '0;
                issuing <= 1'b1;
                rd_vld  <= 1'b0;
                rd_last <= 1'b0;
                found   <= 1'b0;
              end
              rdt_pkg::ACT_RECV: begin
                // An empty list restarts at the received number; otherwise only the next
                // consecutive number is taken, and only while there is room.
                strobe                  <= 1'b1;
                result.kind             <= rdt_pkg::KIND_RECEIVE;
                result.seq_out          <= item.seq_in;
                result.pending_nonempty <= 1'b1;
                result.last             <= 1'b1;
                if (pending_count == '0) begin
                  pending_first <= item.seq_in;
                  pending_count <= CW'(1);
                  result.ok     <= 1'b1;
                end else if (item.seq_in == pending_first + {{(SW-CW){1'b0}}, pending_count}
                             && pending_count < CW'(PENDING_DEPTH)) begin
                  pending_count <= pending_count + CW'(1);
                  result.ok     <= 1'b1;
                end else begin
                  result.ok <= 1'b0;
                end
              end
              rdt_pkg::ACT_DRAIN: begin
                if (pending_count == '0) begin
                  strobe                  <= 1'b1;
                  result.kind             <= rdt_pkg::KIND_NOTHING;
                  result.seq_out          <= '0;
                  result.ok               <= 1'b0;
                  result.pending_nonempty <= 1'b0;
                  result.last             <= 1'b1;
                end else begin
                  state         <= S_DRAIN;
                  drain_n       <= pending_count;
                  drain_k       <= '0;
                  pending_count <= '0;
                end
              end
              default: begin
                strobe                  <= 1'b1;
                result.kind             <= rdt_pkg::KIND_NOTHING;
                result.seq_out          <= '0;
                result.ok               <= 1'b0;
                result.pending_nonempty <= (pending_count != '0);
                result.last             <= 1'b1;
              end
            endcase
          end
        end

        S_SCAN: begin
          // One read is issued per cycle; its word is tested in the next cycle.
          if (issuing) begin
            if (idx == LAST_SLOT) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + IW'(1);
            end
          end
          rd_vld  <= issuing;
          rd_idx  <= idx;
          rd_last <= issuing && (idx == LAST_SLOT);
          if (rd_vld) begin
            if (hit) begin
              found    <= 1'b1;
              pick     <= rd_idx;
              best_age <= age;
              best_seq <= rd_seq;
            end
            if (rd_last) begin
              state <= S_FIN;
            end
          end
        end

        S_FIN: begin
          state                   <= S_IDLE;
          strobe                  <= 1'b1;
          result.pending_nonempty <= (pending_count != '0);
          result.last             <= 1'b1;
          case (op)
            rdt_pkg::ACT_SEND: begin
              result.kind    <= rdt_pkg::KIND_ASSIGNED;
              result.seq_out <= next_seq;
              result.ok      <= found;
              if (found) begin
                flight_valid[pick] <= 1'b1;
                next_seq           <= next_seq + SW'(1);
              end
            end
            rdt_pkg::ACT_ACK: begin
              result.kind    <= rdt_pkg::KIND_ACK;
              result.seq_out <= seq_q;
              result.ok      <= found;
              if (found) begin
                flight_valid[pick] <= 1'b0;
              end
            end
            default: begin
              if (found) begin
                flight_valid[pick] <= 1'b0;
                result.kind        <= rdt_pkg::KIND_FAIL;
                result.seq_out     <= best_seq;
                result.ok          <= 1'b1;
              end else begin
                result.kind    <= rdt_pkg::KIND_NOTHING;
                result.seq_out <= '0;
                result.ok      <= 1'b0;
              end
            end
          endcase
        end

        S_DRAIN: begin
          // Pending acks go out oldest first; the list is already cleared.
          strobe                  <= 1'b1;
          result.kind             <= rdt_pkg::KIND_PENDING;
          result.seq_out          <= pending_first + {{(SW-CW){1'b0}}, drain_k};
          result.ok               <= 1'b1;
          result.pending_nonempty <= 1'b0;
          result.last             <= (drain_k + CW'(1) == drain_n);
          drain_k                 <= drain_k + CW'(1);
          if (drain_k + CW'(1) == drain_n) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
